@@ hw/rtl/skit_pkg.sv @@
// Package: sizes, op codes, status codes, state type and key helpers.
package skit_pkg;

  localparam int ENTRIES_DEF = 256;
  localparam int KEY_BYTES_DEF = 8;
  localparam int KEY_W = 64;
  localparam int LEN_W = 4;
  localparam int POS_W = 48;

  typedef enum logic [3:0] {
    OP_INSERT = 4'd0,
    OP_DELETE = 4'd1,
    OP_SEEK   = 4'd2,
    OP_UPDATE = 4'd3,
    OP_FIRST  = 4'd4,
    OP_LAST   = 4'd5,
    OP_NEXT   = 4'd6,
    OP_PREV   = 4'd7,
    OP_CLEAR  = 4'd8
  } op_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DUP = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHUP,
    S_SHDN,
    S_RDONE,
    S_OUT
  } state_t;

  // Mask of the leading n bytes of a key held in the low kb bytes.
  function automatic logic [KEY_W-1:0] lead_mask(input logic [LEN_W-1:0] n,
                                                 input int kb);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (b < kb && 32'(b) < 32'(n)) begin
        m[8*(kb-1-b) +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] l,
                                                 input int kb);
    return (32'(l) > kb) ? LEN_W'(kb) : l;
  endfunction

endpackage

@@ hw/rtl/sorted_key_index_table.sv @@
// Top level: sorted key index table with walk and shift over one entry memory.
// Throughput: one word in flight; the next word is taken the cycle after the result is
// loaded into the output register. Reset (rst, synchronous): count, cursor, control clear.
module sorted_key_index_table #(
  parameter int ENTRIES = skit_pkg::ENTRIES_DEF,
  parameter int KEY_BYTES = skit_pkg::KEY_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // op[3:0], key[67:4], key_length[71:68], position[119:72],
  // dup_ok[120], any_position[121], zero pad [127:122]
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[1:0], found_position[49:2], key_out[113:50],
  // key_length_out[117:114], entry_count[126:118], zero pad [127]
  output logic [127:0] m_tdata
);
  localparam int AW = $clog2(ENTRIES);
  localparam int CW = AW + 1;
  localparam int EW = skit_pkg::KEY_W + skit_pkg::LEN_W + skit_pkg::POS_W;
  localparam logic [skit_pkg::KEY_W-1:0] KMASK =
    skit_pkg::lead_mask(skit_pkg::LEN_W'(KEY_BYTES), KEY_BYTES);

  logic [EW-1:0] mem [ENTRIES];
  logic [EW-1:0] rdata;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  skit_pkg::state_t state, state_next;
  logic [CW-1:0] count, idx, tgt;
  logic [AW-1:0] cursor;
  logic          cursor_valid;
  logic [3:0]    op;
  logic [skit_pkg::KEY_W-1:0] key;
  logic [skit_pkg::LEN_W-1:0] len;
  logic [skit_pkg::POS_W-1:0] pos;
  logic          dupes, anyp;
  logic [EW-1:0] carry;
  logic [127:0]  res;
  logic [127:0]  out;
  logic          out_valid;
  logic          rd_pend;

  // Fields of the entry just read.
  logic [skit_pkg::KEY_W-1:0] e_key;
  logic [skit_pkg::LEN_W-1:0] e_len;
  logic [skit_pkg::POS_W-1:0] e_pos;
  assign e_key = rdata[skit_pkg::KEY_W-1:0];
  assign e_len = rdata[skit_pkg::KEY_W +: skit_pkg::LEN_W];
  assign e_pos = rdata[skit_pkg::KEY_W+skit_pkg::LEN_W +: skit_pkg::POS_W];

  logic [skit_pkg::LEN_W-1:0] mlen;
  logic [skit_pkg::KEY_W-1:0] cm, ka, kb;
  logic cmp_le, cmp_eq;
  always_comb begin
    mlen = (len > e_len) ? len : e_len;
    cm = skit_pkg::lead_mask(mlen, KEY_BYTES);
    ka = key & cm;
    kb = e_key & cm;
    cmp_le = ka <= kb;
    cmp_eq = ka == kb;
  end

  logic hit;
  always_comb begin
    unique case (op)
      skit_pkg::OP_INSERT: hit = cmp_le;
      skit_pkg::OP_DELETE: hit = cmp_eq && (anyp || e_pos == pos);
      skit_pkg::OP_SEEK:   hit = cmp_eq;
      skit_pkg::OP_UPDATE: hit = e_pos == pos;
      default:             hit = 1'b0;
    endcase
  end

  assign s_tready = (state == skit_pkg::S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata = out;

  function automatic logic [127:0] pack(logic [1:0] st, logic [skit_pkg::POS_W-1:0] p,
                                        logic [skit_pkg::KEY_W-1:0] k,
                                        logic [skit_pkg::LEN_W-1:0] l, logic [CW-1:0] c);
    logic [127:0] r;
    r = '0;
    r[1:0] = st;
    r[49:2] = p;
    r[113:50] = k;
    r[117:114] = l;
    r[126:118] = 9'(c);
    return r;
  endfunction

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      skit_pkg::S_IDLE: if (s_tvalid) begin
        state_next = skit_pkg::S_SCAN;
      end
      skit_pkg::S_SCAN: if (!rd_pend) begin
        state_next = skit_pkg::S_SCAN;
      end
      skit_pkg::S_OUT: if (!out_valid || m_tready) begin
        state_next = skit_pkg::S_IDLE;
      end
      default: state_next = state;
    endcase
  end

  // Load the result once the previous word has left.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == skit_pkg::S_OUT && (!out_valid || m_tready)) begin
      out <= res;
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer: S_SCAN walks entries, S_SHUP/S_SHDN shift, S_RDONE reads one entry, S_OUT emits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skit_pkg::S_IDLE;
      count <= '0;
      cursor <= '0;
      cursor_valid <= 1'b0;
      rd_pend <= 1'b0;
      we <= 1'b0;
    end else begin
      we <= 1'b0;
      unique case (state)
        skit_pkg::S_IDLE: begin
          if (s_tvalid) begin
            op <= s_tdata[3:0];
            key <= s_tdata[67:4] & KMASK;
            len <= skit_pkg::clamp_len(s_tdata[71:68], KEY_BYTES);
            pos <= s_tdata[119:72];
            dupes <= s_tdata[120];
            anyp <= s_tdata[121];
            idx <= '0;
            rd_pend <= 1'b0;
            unique case (s_tdata[3:0])
              skit_pkg::OP_INSERT, skit_pkg::OP_DELETE, skit_pkg::OP_SEEK,
              skit_pkg::OP_UPDATE: begin
                raddr <= '0;
                state <= skit_pkg::S_SCAN;
              end
              skit_pkg::OP_FIRST, skit_pkg::OP_LAST, skit_pkg::OP_NEXT,
              skit_pkg::OP_PREV: begin
                tgt <= (s_tdata[3:0] == skit_pkg::OP_FIRST) ? '0 :
                       (s_tdata[3:0] == skit_pkg::OP_LAST) ? count - 1'b1 :
                       CW'(cursor);
                raddr <= (s_tdata[3:0] == skit_pkg::OP_FIRST) ? '0 :
                         (s_tdata[3:0] == skit_pkg::OP_LAST) ? AW'(count - 1'b1) :
                         cursor;
                state <= skit_pkg::S_RDONE;
              end
              skit_pkg::OP_CLEAR: begin
                count <= '0;
                cursor <= '0;
                cursor_valid <= 1'b0;
                res <= pack(skit_pkg::ST_OK, '0, '0, '0, '0);
                state <= skit_pkg::S_OUT;
              end
              default: begin
                res <= pack(skit_pkg::ST_OK, '0, '0, '0, count);
                state <= skit_pkg::S_OUT;
              end
            endcase
          end
        end
        skit_pkg::S_SCAN: begin
          if (!rd_pend) begin
            // read of raddr issued this cycle, data next
            if (idx >= count) begin
              // walked off the end
              if (op == skit_pkg::OP_INSERT) begin
                if (count >= CW'(ENTRIES)) begin
                  res <= pack(skit_pkg::ST_FULL, '0, '0, '0, count);
                  state <= skit_pkg::S_OUT;
                end else begin
                  we <= 1'b1;
                  waddr <= AW'(count);
                  wdata <= {pos, len, key};
                  count <= count + 1'b1;
                  res <= pack(skit_pkg::ST_OK, pos, '0, '0, count + 1'b1);
                  state <= skit_pkg::S_OUT;
                end
              end else begin
                res <= pack(skit_pkg::ST_NOTFOUND, '0, '0, '0, count);
                state <= skit_pkg::S_OUT;
              end
            end else begin
              rd_pend <= 1'b1;
            end
          end else if (hit) begin
            rd_pend <= 1'b0;
            unique case (op)
              skit_pkg::OP_INSERT: begin
                if (!dupes && cmp_eq) begin
                  res <= pack(skit_pkg::ST_DUP, '0, '0, '0, count);
                  state <= skit_pkg::S_OUT;
                end else if (count >= CW'(ENTRIES)) begin
                  res <= pack(skit_pkg::ST_FULL, '0, '0, '0, count);
                  state <= skit_pkg::S_OUT;
                end else begin
                  // write new entry, carry old one up
                  we <= 1'b1;
                  waddr <= AW'(idx);
                  wdata <= {pos, len, key};
                  carry <= rdata;
                  if (cursor_valid && idx <= CW'(cursor)) begin
                    cursor <= cursor + 1'b1;
                  end
                  idx <= idx + 1'b1;
                  raddr <= AW'(idx + 1'b1);
                  res <= pack(skit_pkg::ST_OK, pos, '0, '0, count + 1'b1);
                  state <= skit_pkg::S_SHUP;
                end
              end
              skit_pkg::OP_DELETE: begin
                res <= pack(skit_pkg::ST_OK, e_pos, '0, '0, count - 1'b1);
                if (cursor_valid) begin
                  if (idx == CW'(cursor)) begin
                    cursor_valid <= 1'b0;
                  end else if (idx < CW'(cursor)) begin
                    cursor <= cursor - 1'b1;
                  end
                end
                raddr <= AW'(idx + 1'b1);
                state <= skit_pkg::S_SHDN;
              end
              skit_pkg::OP_SEEK: begin
                res <= pack(skit_pkg::ST_OK, e_pos, '0, '0, count);
                cursor <= AW'(idx);
                cursor_valid <= 1'b1;
                state <= skit_pkg::S_OUT;
              end
              default: begin
                we <= 1'b1;
                waddr <= AW'(idx);
                wdata <= {e_pos, e_len, (e_key & ~skit_pkg::lead_mask(len, KEY_BYTES))
                          | (key & skit_pkg::lead_mask(len, KEY_BYTES))};
                res <= pack(skit_pkg::ST_OK, pos, '0, '0, count);
                state <= skit_pkg::S_OUT;
              end
            endcase
          end else begin
            rd_pend <= 1'b0;
            idx <= idx + 1'b1;
            raddr <= AW'(idx + 1'b1);
          end
        end
        skit_pkg::S_SHUP: begin
          // idx: slot for carry; raddr = idx issued last cycle.
          if (!rd_pend) begin
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            we <= 1'b1;
            waddr <= AW'(idx);
            wdata <= carry;
            carry <= rdata;
            if (idx >= count) begin
              count <= count + 1'b1;
              state <= skit_pkg::S_OUT;
            end else begin
              idx <= idx + 1'b1;
              raddr <= AW'(idx + 1'b1);
            end
          end
        end
        skit_pkg::S_SHDN: begin
          // move entry idx+1 to idx
          if (idx + 1'b1 >= count) begin
            count <= count - 1'b1;
            state <= skit_pkg::S_OUT;
          end else if (!rd_pend) begin
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            we <= 1'b1;
            waddr <= AW'(idx);
            wdata <= rdata;
            idx <= idx + 1'b1;
            raddr <= AW'(idx + 2'd2);
          end
        end
        skit_pkg::S_RDONE: begin
          if (!rd_pend) begin
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            state <= skit_pkg::S_OUT;
            if (op == skit_pkg::OP_FIRST || op == skit_pkg::OP_LAST) begin
              if (count == '0) begin
                res <= pack(skit_pkg::ST_NOTFOUND, '0, '0, '0, count);
              end else begin
                res <= pack(skit_pkg::ST_OK, e_pos,
                            e_key & skit_pkg::lead_mask(e_len, KEY_BYTES), e_len, count);
              end
            end else if (!cursor_valid || CW'(cursor) >= count) begin
              cursor_valid <= 1'b0;
              res <= pack(skit_pkg::ST_NOTFOUND, '0, '0, '0, count);
            end else begin
              res <= pack(skit_pkg::ST_OK, e_pos,
                          e_key & skit_pkg::lead_mask(e_len, KEY_BYTES), e_len, count);
              if (op == skit_pkg::OP_NEXT) begin
                if (tgt + 1'b1 >= count) begin
                  cursor_valid <= 1'b0;
                end else begin
                  cursor <= cursor + 1'b1;
                end
              end else if (cursor == '0) begin
                cursor_valid <= 1'b0;
              end else begin
                cursor <= cursor - 1'b1;
              end
            end
          end
        end
        default: begin
          state <= state_next;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/skit_checker.sv @@
// Checker: port-level properties of the key index table, bound to the top.
module skit_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata
);
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[127] == 1'b0) else $error("pad bit set");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[126:118] <= 9'd256) else $error("count out of range");
  a_rst: assert property (@(posedge clk) rst |=> s_tready && !m_tvalid)
    else $error("not idle after reset");
endmodule

bind sorted_key_index_table skit_checker u_skit_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));

@@ test/tb_sorted_key_index_table.sv @@
// Testbench for the sorted key index table: directed table, fill to full, random ops; predictor checks.
`timescale 1ns / 100ps

module tb_sorted_key_index_table;

  localparam int NENT = 256;
  localparam int KB = 8;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] pos;
    logic [63:0] key;
    logic [3:0]  len;
    logic [8:0]  count;
  } answer_t;

  typedef struct {
    skit_pkg::op_t op;
    logic [63:0] key;
    logic [3:0]  len;
    logic [47:0] pos;
    logic        dupes;
    logic        anyp;
    logic        fixed;
    answer_t     ans;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [127:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [127:0] m_tdata;

  sorted_key_index_table dut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // table shadow
  logic [63:0] tab_key [NENT];
  logic [3:0]  tab_len [NENT];
  logic [47:0] tab_pos [NENT];
  int tab_count = 0;
  int cur = 0;
  bit cur_ok = 0;

  answer_t pending[$];
  int errors = 0;
  int mism = 0;
  int rx_wait = 0;
  bit long_stall = 0;

  function automatic logic [63:0] byte_mask(int n);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < KB; b++) if (b < n) m[8*(KB-1-b) +: 8] = 8'hFF;
    return m;
  endfunction

  function automatic int key_order(logic [63:0] a, int la, logic [63:0] b, int lb);
    logic [63:0] m;
    m = byte_mask(la > lb ? la : lb);
    if ((a & m) < (b & m)) return -1;
    return ((a & m) > (b & m)) ? 1 : 0;
  endfunction

  function automatic answer_t table_step(row_t r);
    answer_t a;
    int i;
    int l;
    a = '0;
    l = (r.len > KB) ? KB : int'(r.len);
    case (r.op)
      skit_pkg::OP_INSERT: begin
        for (i = 0; i < tab_count; i++)
          if (key_order(r.key, l, tab_key[i], int'(tab_len[i])) <= 0) break;
        if (i < tab_count && !r.dupes &&
            key_order(r.key, l, tab_key[i], int'(tab_len[i])) == 0)
          a.status = skit_pkg::ST_DUP;
        else if (tab_count >= NENT) a.status = skit_pkg::ST_FULL;
        else begin
          for (int j = tab_count; j > i; j--) begin
            tab_key[j] = tab_key[j-1]; tab_len[j] = tab_len[j-1]; tab_pos[j] = tab_pos[j-1];
          end
          tab_key[i] = r.key; tab_len[i] = 4'(l); tab_pos[i] = r.pos;
          tab_count++;
          if (cur_ok && i <= cur) cur++;
          a.pos = r.pos;
        end
      end
      skit_pkg::OP_DELETE: begin
        for (i = 0; i < tab_count; i++)
          if (key_order(r.key, l, tab_key[i], int'(tab_len[i])) == 0 &&
              (r.anyp || tab_pos[i] == r.pos))
            break;
        if (i >= tab_count) a.status = skit_pkg::ST_NOTFOUND;
        else begin
          a.pos = tab_pos[i];
          for (int j = i; j < tab_count - 1; j++) begin
            tab_key[j] = tab_key[j+1]; tab_len[j] = tab_len[j+1]; tab_pos[j] = tab_pos[j+1];
          end
          tab_count--;
          if (cur_ok) begin
            if (i == cur) cur_ok = 0;
            else if (i < cur) cur--;
          end
        end
      end
      skit_pkg::OP_SEEK: begin
        for (i = 0; i < tab_count; i++)
          if (key_order(r.key, l, tab_key[i], int'(tab_len[i])) == 0) break;
        if (i >= tab_count) a.status = skit_pkg::ST_NOTFOUND;
        else begin
          a.pos = tab_pos[i]; cur = i; cur_ok = 1;
        end
      end
      skit_pkg::OP_UPDATE: begin
        for (i = 0; i < tab_count; i++) if (tab_pos[i] == r.pos) break;
        if (i >= tab_count) a.status = skit_pkg::ST_NOTFOUND;
        else begin
          tab_key[i] = (tab_key[i] & ~byte_mask(l)) | (r.key & byte_mask(l));
          a.pos = r.pos;
        end
      end
      skit_pkg::OP_FIRST, skit_pkg::OP_LAST: begin
        if (tab_count == 0) a.status = skit_pkg::ST_NOTFOUND;
        else begin
          i = (r.op == skit_pkg::OP_FIRST) ? 0 : tab_count - 1;
          a.pos = tab_pos[i]; a.key = tab_key[i] & byte_mask(int'(tab_len[i]));
          a.len = tab_len[i];
        end
      end
      skit_pkg::OP_NEXT, skit_pkg::OP_PREV: begin
        if (!cur_ok || cur >= tab_count) begin
          cur_ok = 0; a.status = skit_pkg::ST_NOTFOUND;
        end else begin
          a.pos = tab_pos[cur]; a.key = tab_key[cur] & byte_mask(int'(tab_len[cur]));
          a.len = tab_len[cur];
          if (r.op == skit_pkg::OP_NEXT) begin
            if (cur + 1 >= tab_count) cur_ok = 0; else cur++;
          end else begin
            if (cur == 0) cur_ok = 0; else cur--;
          end
        end
      end
      skit_pkg::OP_CLEAR: begin
        tab_count = 0; cur = 0; cur_ok = 0;
      end
      default: ;
    endcase
    a.count = 9'(tab_count);
    return a;
  endfunction

  function automatic logic [127:0] pack_word(row_t r);
    logic [127:0] w;
    w = '0;
    w[3:0] = r.op; w[67:4] = r.key; w[71:68] = r.len; w[119:72] = r.pos;
    w[120] = r.dupes; w[121] = r.anyp;
    return w;
  endfunction

  // Hold the word until taken; drop valid only when a gap follows.
  task automatic send(row_t r);
    answer_t a;
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= pack_word(r);
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    a = table_step(r);
    if (r.fixed) pending.push_back(r.ans); else pending.push_back(a);
  endtask

  function automatic row_t mk(skit_pkg::op_t op, logic [63:0] k, int l, logic [47:0] p,
                              bit d = 0, bit ap = 0);
    row_t r;
    r.op = op; r.key = k; r.len = 4'(l); r.pos = p; r.dupes = d; r.anyp = ap;
    r.fixed = 0; r.ans = '0;
    return r;
  endfunction

  function automatic row_t mkx(skit_pkg::op_t op, answer_t ans);
    row_t r;
    r = mk(op, '0, 0, '0);
    r.fixed = 1; r.ans = ans;
    return r;
  endfunction

  // result side
  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[1:0], m_tdata[49:2], m_tdata[113:50], m_tdata[117:114],
             m_tdata[126:118]};
      if (pending.size() == 0) begin
        errors++;
        if (mism++ < 10) $display("unexpected result %h", got);
      end else begin
        want = pending.pop_front();
        if (got !== want) begin
          errors++;
          if (mism++ < 10)
            $display({"mismatch: exp st=%0d pos=%h key=%h len=%0d cnt=%0d",
                      " / got st=%0d pos=%h key=%h len=%0d cnt=%0d"},
                     want.status, want.pos, want.key, want.len, want.count,
                     got.status, got.pos, got.key, got.len, got.count);
        end
      end
    end
    // after each word taken, draw rx_wait and hold m_tready low until it counts down; hold off during long_stall
    if (rst || long_stall) m_tready <= 1'b0;
    else if (m_tvalid && m_tready) begin
      rx_wait = $urandom_range(0, 3);
      m_tready <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      rx_wait--;
      m_tready <= (rx_wait == 0);
    end else m_tready <= 1'b1;
  end

  function automatic logic [63:0] rnd_key();
    return {$urandom, $urandom};
  endfunction

  initial begin
    row_t dir[$];
    row_t r;
    int k;
    logic [63:0] picks [16];
    int plen [16];
    logic [47:0] ppos [16];
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed
    dir.push_back(mkx(skit_pkg::OP_FIRST, '{skit_pkg::ST_NOTFOUND, 48'd0, 64'd0, 4'd0, 9'd0}));
    dir.push_back(mkx(skit_pkg::OP_NEXT, '{skit_pkg::ST_NOTFOUND, 48'd0, 64'd0, 4'd0, 9'd0}));
    dir.push_back(mk(skit_pkg::OP_DELETE, 64'h1, 8, 48'h1, 0, 1));
    dir.push_back(mk(skit_pkg::OP_INSERT, '1, 8, '1));
    dir.push_back(mk(skit_pkg::OP_INSERT, '0, 0, '0));
    dir.push_back(mk(skit_pkg::OP_INSERT, 64'h4142_0000_0000_0000, 2, 48'h10));
    dir.push_back(mk(skit_pkg::OP_INSERT, 64'h4142_00FF_0000_0000, 2, 48'h11));
    dir.push_back(mk(skit_pkg::OP_INSERT, 64'h4142_0000_0000_0000, 15, 48'h12, 1));
    dir.push_back(mk(skit_pkg::OP_INSERT, 64'h0100_0000_0000_0000, 1, 48'h13));
    dir.push_back(mk(skit_pkg::OP_SEEK, 64'h4142_0000_0000_0000, 2, 0));
    dir.push_back(mk(skit_pkg::OP_NEXT, 0, 0, 0));
    dir.push_back(mk(skit_pkg::OP_PREV, 0, 0, 0));
    dir.push_back(mk(skit_pkg::OP_PREV, 0, 0, 0));
    dir.push_back(mk(skit_pkg::OP_PREV, 0, 0, 0));
    dir.push_back(mk(skit_pkg::OP_UPDATE, 64'h7700_0000_0000_0000, 1, 48'h12));
    dir.push_back(mk(skit_pkg::OP_UPDATE, 64'h7700_0000_0000_0000, 1, 48'hABC));
    dir.push_back(mk(skit_pkg::OP_LAST, 0, 0, 0));
    dir.push_back(mk(skit_pkg::OP_FIRST, 0, 0, 0));
    dir.push_back(mk(skit_pkg::OP_DELETE, 64'h4142_0000_0000_0000, 2, 48'h11));
    dir.push_back(mk(skit_pkg::OP_DELETE, 64'h4142_0000_0000_0000, 2, 48'h99, 0, 1));
    dir.push_back(mk(skit_pkg::op_t'(4'd9), '1, 8, '1));
    dir.push_back(mk(skit_pkg::op_t'(4'd15), '1, 8, '1));
    dir.push_back(mk(skit_pkg::OP_CLEAR, 0, 0, 0));
    dir.push_back(mkx(skit_pkg::OP_LAST, '{skit_pkg::ST_NOTFOUND, 48'd0, 64'd0, 4'd0, 9'd0}));
    foreach (dir[i]) send(dir[i]);

    // fill past capacity to reach table full
    for (int i = 0; i < 16; i++) begin
      picks[i] = rnd_key(); plen[i] = $urandom_range(0, 15);
      ppos[i] = 48'({$urandom, $urandom});
    end
    for (int i = 0; i < 260; i++) begin
      r = mk(skit_pkg::OP_INSERT, rnd_key(), $urandom_range(0, 15),
             48'({$urandom, $urandom}), 1);
      if (i == 30) begin
        // receiver holds off, so results back up and the inserts stall
        long_stall = 1;
        fork
          begin repeat (400) @(posedge clk); long_stall = 0; end
        join_none
      end
      send(r);
    end
    r = mk(skit_pkg::OP_INSERT, 0, 0, 0, 1); send(r);
    // drain before continuing
    s_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    send(mk(skit_pkg::OP_CLEAR, 0, 0, 0));

    // random mix, mostly over a small key pool
    for (int i = 0; i < 120; i++) begin
      k = $urandom_range(0, 15);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: r = mk(skit_pkg::OP_INSERT, picks[k], plen[k],
                                 ppos[$urandom_range(0, 15)], 1'($urandom_range(0, 1)));
        6, 7, 8: r = mk(skit_pkg::OP_DELETE, picks[k], plen[k], ppos[$urandom_range(0, 15)],
                        0, 1'($urandom_range(0, 1)));
        9, 10: r = mk(skit_pkg::OP_SEEK, picks[k], plen[k], 0);
        11: r = mk(skit_pkg::OP_UPDATE, rnd_key(), $urandom_range(0, 15), ppos[k]);
        12: r = mk(skit_pkg::OP_FIRST, rnd_key(), 0, 0);
        13: r = mk(skit_pkg::OP_LAST, 0, 0, 48'({$urandom, $urandom}));
        14, 15: r = mk(skit_pkg::OP_NEXT, 0, 0, 0);
        16, 17: r = mk(skit_pkg::OP_PREV, 0, 0, 0);
        18: r = (($urandom_range(0, 9) == 0) ? mk(skit_pkg::OP_CLEAR, 0, 0, 0)
                 : mk(skit_pkg::op_t'(4'($urandom_range(9, 15))), rnd_key(), 0, 0, 1, 1));
        default: r = mk(skit_pkg::OP_INSERT, rnd_key(), $urandom_range(0, 15),
                        48'({$urandom, $urandom}), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
      endcase
      send(r);
    end

    s_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
